/* sv/bimt_pkg.sv */
// Shared constants, types and register codes for the beat interval median tempo block.
package bimt_pkg;

    localparam int RING_DEPTH      = 8;
    localparam int IDX_W           = $clog2(RING_DEPTH);
    localparam int CNT_W           = $clog2(RING_DEPTH + 1);

    localparam int TIME_W          = 32;
    localparam int IVL_W           = 16;
    localparam int CFG_W           = 16;
    localparam int CFG_IDX_W       = 1;
    localparam int COUNT_OUT_W     = 4;
    localparam int TEMPO_W         = 19;

    localparam int TEMPO_NUMERATOR = 15360000;    // 60000 * 256
    localparam int NUM_W           = $clog2(TEMPO_NUMERATOR + 1);
    localparam int DIV_CNT_W       = $clog2(NUM_W + 1);

    localparam logic [CFG_W-1:0] MIN_INTERVAL_RESET = CFG_W'(300);
    localparam logic [CFG_W-1:0] MAX_INTERVAL_RESET = CFG_W'(1200);
    localparam logic [IVL_W-1:0] MEDIAN_FLOOR_MS    = IVL_W'(50);
    localparam logic [CNT_W-1:0] MIN_FOR_TEMPO      = CNT_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_INTERVAL = 1'b0,
        CFG_MAX_INTERVAL = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CAPT,
        S_SCAN,
        S_MED,
        S_DIV,
        S_OUT
    } t_state;

endpackage

/* sv/beat_interval_median_tempo_core.sv */
// Median inter-beat interval tempo estimator: ring store, rank-count median and serial divider.
//
//  Channel   Direction  Handshake            Payload
//  beat in   input      i_valid / o_stall    i_beat_time_ms[31:0]
//  result    output     o_valid / i_stall    o_interval_accepted, o_interval_ms,
//                                            o_stored_count, o_tempo_valid, o_tempo_bpm_q8
//  config    input      i_cfg_we             i_cfg_index, i_cfg_data[15:0]
//
//  A beat that does not refresh the tempo goes from acceptance to the output state. A
//  tempo refresh ranks up to n candidates from the n stored intervals, comparing each
//  with every stored interval, then takes the median, divides when it is above 50 ms
//  and outputs; its length is set by the single comparator and the one-bit-a-cycle
//  divider. o_stall is high from acceptance until the result is loaded into the output
//  register. Reset (synchronous, active low) clears the previous beat time, ring
//  pointers and tempo; ring entries are never read unfilled.
module beat_interval_median_tempo_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // beat input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bimt_pkg::TIME_W-1:0]         i_beat_time_ms,
    // result output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_interval_accepted,
    output logic [bimt_pkg::TIME_W-1:0]         o_interval_ms,
    output logic [bimt_pkg::COUNT_OUT_W-1:0]    o_stored_count,
    output logic                                o_tempo_valid,
    output logic [bimt_pkg::TEMPO_W-1:0]        o_tempo_bpm_q8,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [bimt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bimt_pkg::CFG_W-1:0]          i_cfg_data
);
    import bimt_pkg::*;

    // control and configuration
    t_state                 r_state, n_state;
    logic [CFG_W-1:0]       r_min, r_max;
    logic [TIME_W-1:0]      r_last;
    logic [IDX_W-1:0]       r_widx;
    logic [CNT_W-1:0]       r_fill;
    logic [TEMPO_W-1:0]     r_tempo;

    // result waiting for the output register
    logic                   r_res_acc;
    logic [TIME_W-1:0]      r_res_int;

    // interval ring, one write and one registered read port
    logic [IVL_W-1:0]       r_ring [RING_DEPTH];
    logic [IVL_W-1:0]       r_rd_data;
    logic [IDX_W-1:0]       rd_addr;
    logic                   ring_we;

    // rank-count median search
    logic [IDX_W-1:0]       r_i;
    logic [CNT_W-1:0]       r_j;
    logic [IVL_W-1:0]       r_cand;
    logic [CNT_W-1:0]       r_less, r_eq;
    logic [IVL_W-1:0]       r_lo, r_hi;
    logic                   r_lo_ok, r_hi_ok;

    // serial divider
    logic [IVL_W-1:0]       r_div;
    logic [IVL_W-1:0]       r_rem;
    logic [NUM_W-1:0]       r_quo;
    logic [DIV_CNT_W-1:0]   r_dcnt;

    // output register
    logic                   r_o_valid;
    logic                   r_o_acc;
    logic [TIME_W-1:0]      r_o_int;
    logic [COUNT_OUT_W-1:0] r_o_cnt;
    logic                   r_o_tv;
    logic [TEMPO_W-1:0]     r_o_tempo;

    // combinational
    logic                   in_acc, out_free;
    logic [TIME_W-1:0]      interval;
    logic                   in_bounds;
    logic [CNT_W-1:0]       fill_nx;
    logic                   d_lt, d_eq;
    logic [CNT_W-1:0]       less_nx, eq_nx, k_lo, k_hi;
    logic                   lo_hit, hi_hit, last_scan, last_cand, rank_done;
    logic [IVL_W:0]         mid_sum;
    logic [IVL_W-1:0]       med;
    logic [IVL_W:0]         trial;
    logic                   trial_ge;
    logic [IVL_W-1:0]       rem_nx;

    // ---------------------------------------------------------------
    // Beat acceptance: interval is taken modulo 2^32; a zero previous
    // time means there is nothing to measure.
    // ---------------------------------------------------------------
    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign out_free  = !r_o_valid || !i_stall;
    assign interval  = i_beat_time_ms - r_last;
    assign in_bounds = (interval >= TIME_W'(r_min)) && (interval <= TIME_W'(r_max));
    assign ring_we   = in_acc && (r_last != '0) && in_bounds;
    assign fill_nx   = (r_fill < CNT_W'(RING_DEPTH)) ? r_fill + CNT_W'(1) : r_fill;

    // ---------------------------------------------------------------
    // Rank counting: every filled entry is compared against the
    // current candidate; its sorted positions are [less, less+eq-1].
    // The lower and upper middle positions pick the median pair.
    // ---------------------------------------------------------------
    assign d_lt      = r_rd_data < r_cand;
    assign d_eq      = r_rd_data == r_cand;
    assign less_nx   = r_less + CNT_W'(d_lt);
    assign eq_nx     = r_eq + CNT_W'(d_eq);
    assign k_lo      = (r_fill - CNT_W'(1)) >> 1;
    assign k_hi      = r_fill >> 1;
    assign lo_hit    = (less_nx <= k_lo) && (k_lo < less_nx + eq_nx);
    assign hi_hit    = (less_nx <= k_hi) && (k_hi < less_nx + eq_nx);
    assign last_scan = (r_j == r_fill);
    assign last_cand = (r_i == IDX_W'(r_fill - CNT_W'(1)));
    assign rank_done = last_scan
                       && (((r_lo_ok || lo_hit) && (r_hi_ok || hi_hit)) || last_cand);

    // floored mean of the middle pair (equal for an odd count)
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign med       = mid_sum[IVL_W:1];

    // restoring divide step, one quotient bit a cycle
    assign trial     = {r_rem, r_quo[NUM_W-1]};
    assign trial_ge  = trial >= {1'b0, r_div};
    assign rem_nx    = trial_ge ? IVL_W'(trial - {1'b0, r_div}) : IVL_W'(trial);

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (ring_we && (fill_nx >= MIN_FOR_TEMPO)) begin
                        n_state = S_START;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_START: n_state = S_CAPT;
            S_CAPT:  n_state = S_SCAN;
            S_SCAN: begin
                if (last_scan) begin
                    n_state = rank_done ? S_MED : S_CAPT;
                end
            end
            S_MED:   n_state = (med > MEDIAN_FLOOR_MS) ? S_DIV : S_OUT;
            S_DIV: begin
                if (r_dcnt == DIV_CNT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs (stall and ring read address)
    // ---------------------------------------------------------------
    always_comb begin
        o_stall = 1'b1;
        rd_addr = '0;
        case (r_state)
            S_IDLE:  o_stall = 1'b0;
            S_START: rd_addr = r_i;
            S_CAPT:  rd_addr = '0;
            S_SCAN:  rd_addr = last_scan ? r_i + IDX_W'(1) : IDX_W'(r_j);
            default: rd_addr = '0;
        endcase
    end

    // ring memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_widx] <= interval[IVL_W-1:0];
        end
        r_rd_data <= r_ring[rd_addr];
    end

    // configuration registers, written whenever enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_INTERVAL_RESET;
            r_max <= MAX_INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_INTERVAL: r_min <= i_cfg_data;
                CFG_MAX_INTERVAL: r_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= '0;
            r_widx    <= '0;
            r_fill    <= '0;
            r_tempo   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc) begin
                r_last <= i_beat_time_ms;
            end
            if (ring_we) begin
                r_widx <= (r_widx == IDX_W'(RING_DEPTH - 1)) ? '0 : r_widx + IDX_W'(1);
                r_fill <= fill_nx;
            end
            if (r_state == S_DIV && r_dcnt == DIV_CNT_W'(1)) begin
                r_tempo <= TEMPO_W'({r_quo[NUM_W-2:0], trial_ge});
            end
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res_acc <= ring_we;
                r_res_int <= (r_last != '0) ? interval : '0;
                r_i       <= '0;
                r_lo_ok   <= 1'b0;
                r_hi_ok   <= 1'b0;
            end
            S_CAPT: begin
                r_cand <= r_rd_data;
                r_j    <= CNT_W'(1);
                r_less <= '0;
                r_eq   <= '0;
            end
            S_SCAN: begin
                r_less <= less_nx;
                r_eq   <= eq_nx;
                if (!last_scan) begin
                    r_j <= r_j + CNT_W'(1);
                end else begin
                    r_i <= r_i + IDX_W'(1);
                    if (lo_hit && !r_lo_ok) begin
                        r_lo    <= r_cand;
                        r_lo_ok <= 1'b1;
                    end
                    if (hi_hit && !r_hi_ok) begin
                        r_hi    <= r_cand;
                        r_hi_ok <= 1'b1;
                    end
                end
            end
            S_MED: begin
                r_div  <= med;
                r_rem  <= '0;
                r_quo  <= NUM_W'(TEMPO_NUMERATOR);
                r_dcnt <= DIV_CNT_W'(NUM_W);
            end
            S_DIV: begin
                r_rem  <= rem_nx;
                r_quo  <= {r_quo[NUM_W-2:0], trial_ge};
                r_dcnt <= r_dcnt - DIV_CNT_W'(1);
            end
            S_OUT: begin
                if (out_free) begin
                    r_o_acc   <= r_res_acc;
                    r_o_int   <= r_res_int;
                    r_o_cnt   <= COUNT_OUT_W'(r_fill);
                    r_o_tv    <= (r_tempo != '0);
                    r_o_tempo <= r_tempo;
                end
            end
            default: ;
        endcase
    end

    assign o_valid             = r_o_valid;
    assign o_interval_accepted = r_o_acc;
    assign o_interval_ms       = r_o_int;
    assign o_stored_count      = r_o_cnt;
    assign o_tempo_valid       = r_o_tv;
    assign o_tempo_bpm_q8      = r_o_tempo;

endmodule

/* tb/sv/beat_interval_median_tempo_core_test.sv */
// Self-checking testbench for the beat interval median tempo core.
module beat_interval_median_tempo_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bimt_pkg::*;

    // Random part: eight phases of this many beats, each under its own bounds.
    localparam int BEATS_PER_PHASE = 220;
    localparam int PHASES          = 8;
    localparam int REPORT_LIMIT    = 10;

    // Opening run under the reset bounds (300..1200 ms): first beat with no
    // history, in-range intervals up to the third (first tempo), too short,
    // too long, a beat at time zero and the beat after it (no history again),
    // a timestamp wrap through all-ones, both bounds exactly and one past each,
    // and enough accepted intervals to lap the ring.
    localparam logic [TIME_W-1:0] WARMUP_TIMES [19] = '{
        32'd1000, 32'd1500, 32'd2100, 32'd2800, 32'd2900, 32'd4200, 32'd0,
        32'd5000, 32'hFFFF_FE00, 32'hFFFF_FFFF, 32'h0000_01FF,
        32'd811, 32'd2011, 32'd2310, 32'd3511, 32'd4311, 32'd5211, 32'd6211,
        32'd6661
    };

    // Bounds lowered to 10..100 ms: small intervals push the median to 50 ms
    // or below, where the tempo must hold; then one under the floor, one on
    // the ceiling.
    localparam logic [TIME_W-1:0] SHORT_TIMES [9] = '{
        32'd7000, 32'd7020, 32'd7050, 32'd7095, 32'd7120, 32'd7170, 32'd7210,
        32'd7211, 32'd7311
    };

    // Bounds per random phase: reset values, widest, narrowest, top only,
    // inverted (nothing accepted), a mid window, one reaching short medians
    // and a slow-tempo window.
    localparam logic [CFG_W-1:0] PHASE_MIN [PHASES] = '{
        16'd300, 16'd51, 16'd51, 16'd65535, 16'd2000, 16'd200, 16'd40, 16'd1000
    };
    localparam logic [CFG_W-1:0] PHASE_MAX [PHASES] = '{
        16'd1200, 16'd65535, 16'd51, 16'd65535, 16'd1000, 16'd400, 16'd120, 16'd3000
    };

    // One result transaction, field for field as the ports carry it.
    typedef struct packed {
        logic                   accepted;
        logic [TIME_W-1:0]      interval_ms;
        logic [COUNT_OUT_W-1:0] count;
        logic                   tempo_valid;
        logic [TEMPO_W-1:0]     tempo;
    } beat_report_t;

    // Mirror of the estimator: bounds, previous beat, interval ring and tempo,
    // plus the queue of reports owed by the core for accepted beats.
    class tempo_mirror;
        logic [CFG_W-1:0]   min_ms;
        logic [CFG_W-1:0]   max_ms;
        logic [TIME_W-1:0]  prev_stamp;
        logic [IVL_W-1:0]   ring [RING_DEPTH];
        int unsigned        wr_idx;
        int unsigned        fill;
        logic [TEMPO_W-1:0] tempo;
        beat_report_t       reports_due [$];
        int unsigned        faults;

        function new();
            min_ms     = MIN_INTERVAL_RESET;
            max_ms     = MAX_INTERVAL_RESET;
            prev_stamp = '0;
            foreach (ring[k]) ring[k] = '0;
            wr_idx     = 0;
            fill       = 0;
            tempo      = '0;
            faults     = 0;
        endfunction

        function void set_bound(t_cfg_idx idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_MIN_INTERVAL: min_ms = val;
                CFG_MAX_INTERVAL: max_ms = val;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return reports_due.size();
        endfunction

        // Median of the filled entries; tempo moves only above the 50 ms floor.
        function void refresh_tempo();
            int unsigned ranked [RING_DEPTH];
            int unsigned key;
            int unsigned j;
            int unsigned mid;
            if (fill < MIN_FOR_TEMPO)
                return;
            for (int i = 0; i < fill; i++)
                ranked[i] = ring[i];
            for (int i = 1; i < fill; i++) begin
                key = ranked[i];
                j   = i;
                while (j > 0 && ranked[j-1] > key) begin
                    ranked[j] = ranked[j-1];
                    j--;
                end
                ranked[j] = key;
            end
            if (fill % 2 == 1)
                mid = ranked[fill/2];
            else
                mid = (ranked[fill/2 - 1] + ranked[fill/2]) / 2;
            if (mid > MEDIAN_FLOOR_MS)
                tempo = TEMPO_W'(TEMPO_NUMERATOR / mid);
        endfunction

        // Accepted beat transaction: advance the mirror and queue its report.
        function void note_beat(logic [TIME_W-1:0] stamp);
            beat_report_t want;
            logic [TIME_W-1:0] gap;
            gap          = '0;
            want.accepted = 1'b0;
            if (prev_stamp != '0) begin
                gap = stamp - prev_stamp;
                if (gap >= min_ms && gap <= max_ms) begin
                    want.accepted = 1'b1;
                    ring[wr_idx]  = gap[IVL_W-1:0];
                    wr_idx        = (wr_idx + 1) % RING_DEPTH;
                    if (fill < RING_DEPTH)
                        fill++;
                    refresh_tempo();
                end
            end
            prev_stamp       = stamp;
            want.interval_ms = gap;
            want.count       = COUNT_OUT_W'(fill);
            want.tempo_valid = (tempo != '0);
            want.tempo       = tempo;
            reports_due.push_back(want);
        endfunction

        // Result transaction: compare against the oldest report owed.
        function void check_report(beat_report_t got);
            beat_report_t want;
            if (reports_due.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("%0t: unexpected result acc=%0b ivl=%0d cnt=%0d tv=%0b tempo=%0d",
                             $realtime, got.accepted, got.interval_ms, got.count,
                             got.tempo_valid, got.tempo);
                return;
            end
            want = reports_due.pop_front();
            if (got.accepted !== want.accepted || got.interval_ms !== want.interval_ms ||
                got.count !== want.count || got.tempo_valid !== want.tempo_valid ||
                got.tempo !== want.tempo) begin
                faults++;
                if (faults <= REPORT_LIMIT) begin
                    $display("%0t: mismatch  expected acc=%0b ivl=%0d cnt=%0d tv=%0b tempo=%0d",
                             $realtime, want.accepted, want.interval_ms, want.count,
                             want.tempo_valid, want.tempo);
                    $display("%0t:           actual   acc=%0b ivl=%0d cnt=%0d tv=%0b tempo=%0d",
                             $realtime, got.accepted, got.interval_ms, got.count,
                             got.tempo_valid, got.tempo);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic                   o_stall;
    logic [TIME_W-1:0]      i_beat_time_ms = '0;
    logic                   o_valid;
    logic                   i_stall        = 1'b0;
    logic                   o_interval_accepted;
    logic [TIME_W-1:0]      o_interval_ms;
    logic [COUNT_OUT_W-1:0] o_stored_count;
    logic                   o_tempo_valid;
    logic [TEMPO_W-1:0]     o_tempo_bpm_q8;
    logic                   i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index    = '0;
    logic [CFG_W-1:0]       i_cfg_data     = '0;

    tempo_mirror sb;
    int unsigned send_idle_pct  = 0;    // chance per cycle of a gap before a beat
    int unsigned recv_stall_pct = 0;    // chance per cycle of stalling the result side

    beat_interval_median_tempo_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_beat_time_ms      (i_beat_time_ms),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_interval_accepted (o_interval_accepted),
        .o_interval_ms       (o_interval_ms),
        .o_stored_count      (o_stored_count),
        .o_tempo_valid       (o_tempo_valid),
        .o_tempo_bpm_q8      (o_tempo_bpm_q8),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run, stalls included.
    initial begin
        #12_000_000;
        $display("beat_interval_median_tempo_core_test failed");
        $finish;
    end

    // Result side: sample at the rising edge, choose next stall at the falling edge.
    initial begin
        beat_report_t seen;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                seen.accepted    = o_interval_accepted;
                seen.interval_ms = o_interval_ms;
                seen.count       = o_stored_count;
                seen.tempo_valid = o_tempo_valid;
                seen.tempo       = o_tempo_bpm_q8;
                sb.check_report(seen);
            end
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // One beat transaction: optional idle gap, then hold valid until accepted.
    // Valid stays high across back-to-back beats; only the payload moves.
    task automatic send_beat(input logic [TIME_W-1:0] stamp);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_beat_time_ms <= stamp;
        do @(posedge i_clk); while (o_stall);
        sb.note_beat(stamp);
    endtask

    // Drop valid and wait for every owed report; every beat yields one,
    // so the core is idle once the queue is empty.
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_bound(idx, val);
    endtask

    // Next timestamp: mostly a well-formed beat inside the window, some on
    // or just past its edges, plus noise (random stamps and zero stamps).
    function automatic logic [TIME_W-1:0] pick_beat(input logic [TIME_W-1:0] prev,
                                                    input int unsigned lo,
                                                    input int unsigned hi);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 12)
            return $urandom;
        if (roll < 24) begin
            case ($urandom_range(3))
                0:       gap = lo - 1;
                1:       gap = lo;
                2:       gap = hi;
                default: gap = hi + 1;
            endcase
        end else begin
            gap = $urandom_range(hi, lo);
        end
        return prev + gap;
    endfunction

    initial begin
        logic [TIME_W-1:0] stamp;
        int unsigned lo;
        int unsigned hi;
        sb = new();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats under the reset bounds, then the short-median case.
        foreach (WARMUP_TIMES[k])
            send_beat(WARMUP_TIMES[k]);
        settle();
        write_reg(CFG_MIN_INTERVAL, 16'd10);
        write_reg(CFG_MAX_INTERVAL, 16'd100);
        foreach (SHORT_TIMES[k])
            send_beat(SHORT_TIMES[k]);
        stamp = SHORT_TIMES[8];

        // Random phases: idle profile cycles none / sender / receiver / both.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(CFG_MIN_INTERVAL, PHASE_MIN[p]);
            write_reg(CFG_MAX_INTERVAL, PHASE_MAX[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            // inverted bounds still get a sensible spread of intervals
            lo = (PHASE_MIN[p] < PHASE_MAX[p]) ? PHASE_MIN[p] : PHASE_MAX[p];
            hi = (PHASE_MIN[p] < PHASE_MAX[p]) ? PHASE_MAX[p] : PHASE_MIN[p];
            repeat (BEATS_PER_PHASE) begin
                stamp = pick_beat(stamp, lo, hi);
                send_beat(stamp);
            end
        end

        // Drain, then allow a full tempo refresh worth of cycles for strays.
        settle();
        repeat (150) @(negedge i_clk);
        if (sb.faults == 0 && sb.pending() == 0)
            $display("beat_interval_median_tempo_core_test passed");
        else
            $display("beat_interval_median_tempo_core_test failed");
        $finish;
    end

endmodule
